>>> src/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared types and constants of the B-spline point transform block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpt_pkg;

  // input item: one coefficient write or one point query
  typedef struct packed {
    logic               command;
    logic [10:0]        coeff_index;
    logic signed [31:0] coeff_x;
    logic signed [31:0] coeff_y;
    logic signed [31:0] coeff_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_t;

  // result item
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               outside;
  } out_t;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_SCALE_X  = 3'd3;
  localparam logic [2:0] REG_SCALE_Y  = 3'd4;
  localparam logic [2:0] REG_SCALE_Z  = 3'd5;

  localparam logic [31:0] SCALE_RESET = 32'h0100_0000;

  // floor(q / 6) = (q * DIV6_RECIP) >> DIV6_SHIFT for q below 2^19
  localparam logic [17:0] DIV6_RECIP = 18'd174763;
  localparam int          DIV6_SHIFT = 20;

endpackage

>>> src/bspline_point_transform.sv
// ----------------------------------------------------------------------------
// bspline_point_transform
// Cubic B-spline free-form deformation of 3D points over a grid of control
// displacement vectors held in an on-chip memory.
// ----------------------------------------------------------------------------
// A coefficient write (command 0) gives no result. A point query (command 1)
// runs on one shared 33x33 multiplier under a sequencer: it locates the point
// on each axis, builds the twelve cubic weights, then for each of the 64
// neighbor control vectors makes one memory read and adds up the weighted
// vector, and last forms the result. A point that falls outside the grid
// goes from locating straight to forming the result. The input is stalled
// for the whole query. The result sits in an output register; a query
// finishing while the previous result is still stalled waits for it to
// drain. The coefficient store has no reset; only written entries may be
// used.
`timescale 1ns / 1ps

module bspline_point_transform #(
  parameter int REGIONS_X = 8,
  parameter int REGIONS_Y = 8,
  parameter int REGIONS_Z = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bpt_pkg::in_t     in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output bpt_pkg::out_t    out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_wdata
);

  localparam int CTRL_X = REGIONS_X + 3;
  localparam int CTRL_Y = REGIONS_Y + 3;
  localparam int CTRL_Z = REGIONS_Z + 3;
  localparam int CTRL_XY = CTRL_X * CTRL_Y;
  localparam int DEPTH = CTRL_XY * CTRL_Z;
  localparam int AW = $clog2(DEPTH);
  localparam int TXW = (REGIONS_X > 1) ? $clog2(REGIONS_X) : 1;
  localparam int TYW = (REGIONS_Y > 1) ? $clog2(REGIONS_Y) : 1;
  localparam int TZW = (REGIONS_Z > 1) ? $clog2(REGIONS_Z) : 1;
  localparam int STEP_J = CTRL_X - 3;
  localparam int STEP_K = CTRL_XY - 3 * CTRL_X - 3;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOC  = 4'd1;
  localparam logic [3:0] ST_LOC2 = 4'd2;
  localparam logic [3:0] ST_T2   = 4'd3;
  localparam logic [3:0] ST_T3   = 4'd4;
  localparam logic [3:0] ST_NUM  = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_DIVW = 4'd7;
  localparam logic [3:0] ST_WA   = 4'd8;
  localparam logic [3:0] ST_WB   = 4'd9;
  localparam logic [3:0] ST_CX   = 4'd10;
  localparam logic [3:0] ST_CY   = 4'd11;
  localparam logic [3:0] ST_CZ   = 4'd12;
  localparam logic [3:0] ST_AZ   = 4'd13;
  localparam logic [3:0] ST_FIN  = 4'd14;

  // configuration registers
  logic signed [31:0] org_x_r, org_y_r, org_z_r;
  logic [31:0]        sc_x_r, sc_y_r, sc_z_r;

  // sequencer and datapath registers
  logic [3:0]         st_r;
  logic [1:0]         ax_r, widx_r, ci_r, cj_r, ck_r;
  logic signed [31:0] pt_x_r, pt_y_r, pt_z_r;
  logic [TXW-1:0]     tx_r;
  logic [TYW-1:0]     ty_r;
  logic [TZW-1:0]     tz_r;
  logic [15:0]        fx_r, fy_r, fz_r;
  logic               outside_r;
  logic signed [65:0] p_r;
  logic [31:0]        t2_r;
  logic [18:0]        q_r [4];
  logic [15:0]        wx_r [4];
  logic [15:0]        wy_r [4];
  logic [15:0]        wz_r [4];
  logic [16:0]        ql_r;
  logic [AW-1:0]      addr_r;
  logic [95:0]        rd_r;
  logic signed [55:0] acc_x_r, acc_y_r, acc_z_r;
  logic               out_valid_r;
  bpt_pkg::out_t      out_r;

  logic [95:0]        mem [DEPTH];

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  // per-axis selections for the locate and weight steps
  logic signed [31:0] sel_pt, sel_org;
  logic [31:0]        sel_sc;
  logic [15:0]        sel_t;
  logic [23:0]        sel_regions;
  logic signed [32:0] diff;
  logic               loc_out;

  // weight numerators
  logic signed [53:0] t1_s, t2_s, t3_s, n0, n1, n2, n3;
  logic signed [53:0] bias;

  logic               in_xfer, out_xfer, wr_ok, last_nb, fin_go;
  logic signed [41:0] sum_x, sum_y, sum_z;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = (st_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign wr_ok = ({21'd0, in_data.coeff_index} < 32'(DEPTH));
  assign last_nb = (ci_r == 2'd3) && (cj_r == 2'd3) && (ck_r == 2'd3);
  assign fin_go = (st_r == ST_FIN) && (!out_valid_r || !out_stall);

  // axis select
  always_comb begin
    case (ax_r)
      2'd0: begin
        sel_pt = pt_x_r; sel_org = org_x_r; sel_sc = sc_x_r; sel_t = fx_r;
        sel_regions = 24'(REGIONS_X);
      end
      2'd1: begin
        sel_pt = pt_y_r; sel_org = org_y_r; sel_sc = sc_y_r; sel_t = fy_r;
        sel_regions = 24'(REGIONS_Y);
      end
      default: begin
        sel_pt = pt_z_r; sel_org = org_z_r; sel_sc = sc_z_r; sel_t = fz_r;
        sel_regions = 24'(REGIONS_Z);
      end
    endcase
  end

  assign diff = {sel_pt[31], sel_pt} - {sel_org[31], sel_org};
  assign loc_out = (sel_sc != 32'd0) &&
                   (diff[32] || (p_r[63:40] >= sel_regions));

  // numerators in units of 2^-48, built from t, t^2 and t^3
  assign t1_s = $signed({38'd0, sel_t});
  assign t2_s = $signed({22'd0, t2_r});
  assign t3_s = $signed({6'd0, p_r[47:0]});
  assign bias = $signed(54'd3 <<< 32);
  assign n0 = $signed(54'd1 <<< 48) - 3 * (t1_s <<< 32) + 3 * (t2_s <<< 16) - t3_s;
  assign n1 = 3 * t3_s - 6 * (t2_s <<< 16) + $signed(54'd4 <<< 48);
  assign n2 = -3 * t3_s + 3 * (t2_s <<< 16) + 3 * (t1_s <<< 32)
              + $signed(54'd1 <<< 48);
  assign n3 = t3_s;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      ST_LOC: begin
        mul_a = $signed({1'b0, diff[31:0]});
        mul_b = $signed({1'b0, sel_sc});
      end
      ST_T2: begin
        mul_a = $signed({17'd0, sel_t});
        mul_b = $signed({17'd0, sel_t});
      end
      ST_T3: begin
        mul_a = $signed(p_r[32:0]);
        mul_b = $signed({17'd0, sel_t});
      end
      ST_DIV: begin
        mul_a = $signed({14'd0, q_r[widx_r]});
        mul_b = $signed({15'd0, bpt_pkg::DIV6_RECIP});
      end
      ST_WA: begin
        mul_a = $signed({17'd0, wx_r[ci_r]});
        mul_b = $signed({17'd0, wy_r[cj_r]});
      end
      ST_WB: begin
        mul_a = $signed(p_r[32:0]);
        mul_b = $signed({17'd0, wz_r[ck_r]});
      end
      ST_CX: begin
        mul_a = $signed({16'd0, p_r[48:32]});
        mul_b = $signed({rd_r[95], rd_r[95:64]});
      end
      ST_CY: begin
        mul_a = $signed({16'd0, ql_r});
        mul_b = $signed({rd_r[63], rd_r[63:32]});
      end
      ST_CZ: begin
        mul_a = $signed({16'd0, ql_r});
        mul_b = $signed({rd_r[31], rd_r[31:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // final sums: point plus floored displacement
  assign sum_x = 42'(pt_x_r) + 42'($signed(acc_x_r[55:16]));
  assign sum_y = 42'(pt_y_r) + 42'($signed(acc_y_r[55:16]));
  assign sum_z = 42'(pt_z_r) + 42'($signed(acc_z_r[55:16]));

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    if (v > 42'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -42'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      sc_x_r  <= bpt_pkg::SCALE_RESET;
      sc_y_r  <= bpt_pkg::SCALE_RESET;
      sc_z_r  <= bpt_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpt_pkg::REG_ORIGIN_X: org_x_r <= cfg_wdata;
        bpt_pkg::REG_ORIGIN_Y: org_y_r <= cfg_wdata;
        bpt_pkg::REG_ORIGIN_Z: org_z_r <= cfg_wdata;
        bpt_pkg::REG_SCALE_X:  sc_x_r  <= cfg_wdata;
        bpt_pkg::REG_SCALE_Y:  sc_y_r  <= cfg_wdata;
        bpt_pkg::REG_SCALE_Z:  sc_z_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // coefficient store
  always_ff @(posedge clk) begin
    if (in_xfer && (in_data.command == bpt_pkg::CMD_WRITE) && wr_ok) begin
      mem[AW'(in_data.coeff_index)] <= {in_data.coeff_x, in_data.coeff_y,
                                        in_data.coeff_z};
    end
    if (st_r == ST_WA) begin
      rd_r <= mem[addr_r];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    p_r <= mul_p;
    if (in_xfer) begin
      pt_x_r  <= in_data.point_x;
      pt_y_r  <= in_data.point_y;
      pt_z_r  <= in_data.point_z;
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_z_r <= '0;
    end
    unique case (st_r)
      ST_LOC2: begin
        if (!loc_out) begin
          case (ax_r)
            2'd0: begin
              tx_r <= (sc_x_r == 32'd0) ? '0 : p_r[40 +: TXW];
              fx_r <= (sc_x_r == 32'd0) ? '0 : p_r[39:24];
            end
            2'd1: begin
              ty_r <= (sc_y_r == 32'd0) ? '0 : p_r[40 +: TYW];
              fy_r <= (sc_y_r == 32'd0) ? '0 : p_r[39:24];
            end
            default: begin
              tz_r <= (sc_z_r == 32'd0) ? '0 : p_r[40 +: TZW];
              fz_r <= (sc_z_r == 32'd0) ? '0 : p_r[39:24];
            end
          endcase
        end
      end
      ST_T3: t2_r <= p_r[31:0];
      ST_NUM: begin
        q_r[0] <= 19'((n0 + bias) >>> 32);
        q_r[1] <= 19'((n1 + bias) >>> 32);
        q_r[2] <= 19'((n2 + bias) >>> 32);
        q_r[3] <= 19'((n3 + bias) >>> 32);
      end
      ST_DIVW: begin
        case (ax_r)
          2'd0:    wx_r[widx_r] <= p_r[bpt_pkg::DIV6_SHIFT +: 16];
          2'd1:    wy_r[widx_r] <= p_r[bpt_pkg::DIV6_SHIFT +: 16];
          default: wz_r[widx_r] <= p_r[bpt_pkg::DIV6_SHIFT +: 16];
        endcase
        addr_r <= AW'(int'(tz_r) * CTRL_XY + int'(ty_r) * CTRL_X + int'(tx_r));
      end
      ST_CX: ql_r <= p_r[48:32];
      ST_CY: acc_x_r <= acc_x_r + 56'(p_r);
      ST_CZ: acc_y_r <= acc_y_r + 56'(p_r);
      ST_AZ: begin
        acc_z_r <= acc_z_r + 56'(p_r);
        if (ci_r != 2'd3) begin
          addr_r <= addr_r + AW'(1);
        end else if (cj_r != 2'd3) begin
          addr_r <= addr_r + AW'(STEP_J);
        end else begin
          addr_r <= addr_r + AW'(STEP_K);
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ax_r        <= '0;
      widx_r      <= '0;
      ci_r        <= '0;
      cj_r        <= '0;
      ck_r        <= '0;
      outside_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result valid: set by the finish step, cleared by a result transfer
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_xfer && (in_data.command == bpt_pkg::CMD_POINT)) begin
            st_r      <= ST_LOC;
            ax_r      <= '0;
            outside_r <= 1'b0;
          end
        end
        ST_LOC: st_r <= ST_LOC2;
        ST_LOC2: begin
          if (loc_out) begin
            outside_r <= 1'b1;
          end
          if (ax_r == 2'd2) begin
            ax_r <= '0;
            st_r <= (outside_r || loc_out) ? ST_FIN : ST_T2;
          end else begin
            ax_r <= ax_r + 2'd1;
            st_r <= ST_LOC;
          end
        end
        ST_T2:  st_r <= ST_T3;
        ST_T3:  st_r <= ST_NUM;
        ST_NUM: begin
          widx_r <= '0;
          st_r   <= ST_DIV;
        end
        ST_DIV: st_r <= ST_DIVW;
        ST_DIVW: begin
          widx_r <= widx_r + 2'd1;
          if (widx_r != 2'd3) begin
            st_r <= ST_DIV;
          end else if (ax_r != 2'd2) begin
            ax_r <= ax_r + 2'd1;
            st_r <= ST_T2;
          end else begin
            ci_r <= '0;
            cj_r <= '0;
            ck_r <= '0;
            st_r <= ST_WA;
          end
        end
        ST_WA: st_r <= ST_WB;
        ST_WB: st_r <= ST_CX;
        ST_CX: st_r <= ST_CY;
        ST_CY: st_r <= ST_CZ;
        ST_CZ: st_r <= ST_AZ;
        ST_AZ: begin
          ci_r <= ci_r + 2'd1;
          if (ci_r == 2'd3) begin
            cj_r <= cj_r + 2'd1;
            if (cj_r == 2'd3) begin
              ck_r <= ck_r + 2'd1;
            end
          end
          st_r <= last_nb ? ST_FIN : ST_WA;
        end
        ST_FIN: begin
          if (fin_go) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_r.outside <= outside_r;
      if (outside_r) begin
        out_r.out_x <= pt_x_r;
        out_r.out_y <= pt_y_r;
        out_r.out_z <= pt_z_r;
      end else begin
        out_r.out_x <= sat32(sum_x);
        out_r.out_y <= sat32(sum_y);
        out_r.out_z <= sat32(sum_z);
      end
    end
  end

`ifndef SYNTHESIS
  // a new result only comes out of the finish step
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == ST_FIN))
    else $error("result raised outside finish step");

  // a point transfer starts the locate step
  a_point_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_data.command == bpt_pkg::CMD_POINT)) |=> (st_r == ST_LOC))
    else $error("point transfer did not start sequencer");

  // the last neighbor ends the accumulation
  a_last_nb: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_AZ) && last_nb) |=> (st_r == ST_FIN))
    else $error("accumulation did not end after last neighbor");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result changed");
`endif

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the B-spline point transform. It fills the control
// grid, sends coefficient writes and point queries under random idling, and
// checks every transform result against a scoreboard that predicts the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// predicts transform results and holds the ones still due from the block
class transform_scoreboard;
  localparam int GRID_DIM    = 8;
  localparam int CTRL_DIM    = GRID_DIM + 3;
  localparam int STORE_DEPTH = CTRL_DIM * CTRL_DIM * CTRL_DIM;

  logic signed [31:0] origin[3];
  logic [31:0]        scale[3];
  logic signed [31:0] coeff_mem[STORE_DEPTH][3];
  bpt_pkg::out_t      due_q[$];
  int                 errors;

  function void reset_state();
    for (int d = 0; d < 3; d++) begin
      origin[d] = '0;
      scale[d]  = bpt_pkg::SCALE_RESET;
    end
    due_q.delete();
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      bpt_pkg::REG_ORIGIN_X: origin[0] = val;
      bpt_pkg::REG_ORIGIN_Y: origin[1] = val;
      bpt_pkg::REG_ORIGIN_Z: origin[2] = val;
      bpt_pkg::REG_SCALE_X:  scale[0]  = val;
      bpt_pkg::REG_SCALE_Y:  scale[1]  = val;
      bpt_pkg::REG_SCALE_Z:  scale[2]  = val;
      default: ;
    endcase
  endfunction

  // tile index and 16-bit fraction of one axis; 0 when outside the grid
  function bit locate(longint pt, int ax, output int tile, output longint frac);
    longint diff;
    longint unsigned d, a, b, u16, sc;
    diff = pt - longint'(origin[ax]);
    sc   = scale[ax];
    tile = 0;
    frac = 0;
    if (sc == 0) begin
      u16 = 0;
    end else if (diff < 0) begin
      return 0;
    end else begin
      d   = diff;
      a   = d * (sc >> 16);
      b   = d * (sc & 64'hFFFF);
      u16 = (a + (b >> 16)) >> 8;
    end
    if ((u16 >> 16) >= GRID_DIM) return 0;
    tile = int'(u16 >> 16);
    frac = longint'(u16 & 64'hFFFF);
    return 1;
  endfunction

  // four uniform cubic weights in Q0.16, rounded half up
  function void spline_weights(longint t, output longint w[4]);
    longint s, s2, s3, t2, t3, m, den;
    longint n[4];
    s   = 65536;
    s2  = s * s;
    s3  = s2 * s;
    t2  = t * t;
    t3  = t2 * t;
    m   = s - t;
    den = 6 * s2;
    n[0] = m * m * m;
    n[1] = 3 * t3 - 6 * t2 * s + 4 * s3;
    n[2] = -3 * t3 + 3 * t2 * s + 3 * t * s2 + s3;
    n[3] = t3;
    for (int i = 0; i < 4; i++) w[i] = (n[i] + 3 * s2) / den;
  endfunction

  function logic signed [31:0] sat32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function void note_input(bpt_pkg::in_t it);
    longint        pt[3];
    int            tile[3];
    longint        frac[3];
    longint        w[3][4];
    longint        acc[3];
    longint        ql;
    int            ci;
    bit            in_grid;
    bpt_pkg::out_t res;
    if (it.command == bpt_pkg::CMD_WRITE) begin
      if (it.coeff_index < STORE_DEPTH) begin
        coeff_mem[it.coeff_index][0] = it.coeff_x;
        coeff_mem[it.coeff_index][1] = it.coeff_y;
        coeff_mem[it.coeff_index][2] = it.coeff_z;
      end
      return;
    end
    pt[0] = it.point_x;
    pt[1] = it.point_y;
    pt[2] = it.point_z;
    in_grid = 1;
    for (int d = 0; d < 3; d++)
      if (!locate(pt[d], d, tile[d], frac[d])) in_grid = 0;
    if (!in_grid) begin
      res = '{out_x: it.point_x, out_y: it.point_y, out_z: it.point_z, outside: 1'b1};
      due_q.push_back(res);
      return;
    end
    for (int d = 0; d < 3; d++) begin
      spline_weights(frac[d], w[d]);
      acc[d] = 0;
    end
    // weighted sum over the 4x4x4 neighborhood
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 4; j++)
        for (int i = 0; i < 4; i++) begin
          ci = (tile[2] + k) * CTRL_DIM * CTRL_DIM + (tile[1] + j) * CTRL_DIM + tile[0] + i;
          ql = (w[0][i] * w[1][j] * w[2][k]) >>> 32;
          for (int d = 0; d < 3; d++) acc[d] += ql * longint'(coeff_mem[ci][d]);
        end
    res.out_x   = sat32(pt[0] + (acc[0] >>> 16));
    res.out_y   = sat32(pt[1] + (acc[1] >>> 16));
    res.out_z   = sat32(pt[2] + (acc[2] >>> 16));
    res.outside = 1'b0;
    due_q.push_back(res);
  endfunction

  function void check(bpt_pkg::out_t got);
    bpt_pkg::out_t exp_r;
    if (due_q.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp_r = due_q.pop_front();
    if (got.out_x !== exp_r.out_x) begin
      $display("%0t: out_x expected %h actual %h", $time, exp_r.out_x, got.out_x);
      errors++;
    end
    if (got.out_y !== exp_r.out_y) begin
      $display("%0t: out_y expected %h actual %h", $time, exp_r.out_y, got.out_y);
      errors++;
    end
    if (got.out_z !== exp_r.out_z) begin
      $display("%0t: out_z expected %h actual %h", $time, exp_r.out_z, got.out_z);
      errors++;
    end
    if (got.outside !== exp_r.outside) begin
      $display("%0t: outside expected %b actual %b", $time, exp_r.outside, got.outside);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int STORE_DEPTH  = 1331;
  localparam int PHASE_ITEMS  = 130;
  localparam int NUM_PHASES   = 4;
  localparam int HOLD_CYCLES  = 3000;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  bpt_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  bpt_pkg::out_t out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  transform_scoreboard sb;
  int send_pct;
  int recv_pct;
  bit hold_req;

  bspline_point_transform i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side stall, with one long hold-off on request
  initial begin : receiver
    int hold_cnt;
    hold_cnt  = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(99) < recv_pct);
      end
    end
  end

  // check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(out_data);
  end

  // one input transfer, then a random gap; starts and ends at a falling edge
  task automatic send_item(bpt_pkg::in_t it);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // wait until every result is in, then let the block settle
  task automatic drain();
    in_valid = 1'b0;
    while (sb.due_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic bpt_pkg::in_t coeff_write(logic [10:0] idx, logic [31:0] cx,
                                               logic [31:0] cy, logic [31:0] cz);
    logic [223:0] rnd;
    bpt_pkg::in_t it;
    rnd            = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it             = rnd[$bits(bpt_pkg::in_t)-1:0];
    it.command     = bpt_pkg::CMD_WRITE;
    it.coeff_index = idx;
    it.coeff_x     = cx;
    it.coeff_y     = cy;
    it.coeff_z     = cz;
    return it;
  endfunction

  function automatic bpt_pkg::in_t point_query(logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pz);
    logic [223:0] rnd;
    bpt_pkg::in_t it;
    rnd        = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it         = rnd[$bits(bpt_pkg::in_t)-1:0];
    it.command = bpt_pkg::CMD_POINT;
    it.point_x = px;
    it.point_y = py;
    it.point_z = pz;
    return it;
  endfunction

  // coefficient value: mostly within +/-2^20, sometimes full range or an extreme
  function automatic logic [31:0] rand_coeff();
    int sel;
    sel = $urandom_range(15);
    if (sel == 0) return 32'h7FFF_FFFF;
    if (sel == 1) return 32'h8000_0000;
    if (sel < 5) return $urandom;
    return $urandom_range(32'h0020_0000) - 32'h0010_0000;
  endfunction

  // coordinate that lands inside the grid on one axis unless the sum with the origin wraps at 32 bits
  function automatic logic [31:0] inside_coord(int ax);
    longint unsigned span, diff;
    if (sb.scale[ax] == 0) return $urandom;
    span = (64'd8 << 40) / sb.scale[ax];
    if (span > (64'd1 << 33)) span = 64'd1 << 33;
    if (span == 0) span = 1;
    diff = {$urandom, $urandom} % span;
    return sb.origin[ax] + diff[31:0];
  endfunction

  function automatic bpt_pkg::in_t rand_item();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return coeff_write(11'($urandom_range(2047)), rand_coeff(), rand_coeff(),
                                     rand_coeff());
    if (sel < 88) return point_query(inside_coord(0), inside_coord(1), inside_coord(2));
    if (sel < 94) return point_query(inside_coord(0), $urandom, inside_coord(2));
    return point_query($urandom, $urandom, $urandom);
  endfunction

  // register settings per phase, extremes among them
  task automatic setup_phase(int ph);
    case (ph)
      0: begin
        write_reg(bpt_pkg::REG_ORIGIN_X, 32'h0);
        write_reg(bpt_pkg::REG_ORIGIN_Y, 32'h0);
        write_reg(bpt_pkg::REG_ORIGIN_Z, 32'h0);
        write_reg(bpt_pkg::REG_SCALE_X, bpt_pkg::SCALE_RESET);
        write_reg(bpt_pkg::REG_SCALE_Y, bpt_pkg::SCALE_RESET);
        write_reg(bpt_pkg::REG_SCALE_Z, bpt_pkg::SCALE_RESET);
      end
      1: begin
        write_reg(bpt_pkg::REG_ORIGIN_X, 32'h8000_0000);
        write_reg(bpt_pkg::REG_ORIGIN_Y, 32'h7FFF_FFFF);
        write_reg(bpt_pkg::REG_ORIGIN_Z, 32'hFFFD_0000);
        write_reg(bpt_pkg::REG_SCALE_X, 32'hFFFF_FFFF);
        write_reg(bpt_pkg::REG_SCALE_Y, 32'h0);
        write_reg(bpt_pkg::REG_SCALE_Z, 32'h0080_0000);
      end
      2: begin
        // X and Y near the top of the range, Z at the bottom, so sums saturate
        write_reg(bpt_pkg::REG_ORIGIN_X, 32'h7FF8_0000);
        write_reg(bpt_pkg::REG_ORIGIN_Y, 32'h7FF8_0000);
        write_reg(bpt_pkg::REG_ORIGIN_Z, 32'h8000_0000);
        write_reg(bpt_pkg::REG_SCALE_X, 32'h0100_0000);
        write_reg(bpt_pkg::REG_SCALE_Y, 32'h0200_0000);
        write_reg(bpt_pkg::REG_SCALE_Z, 32'h0400_0000);
      end
      default: begin
        write_reg(bpt_pkg::REG_ORIGIN_X, $urandom);
        write_reg(bpt_pkg::REG_ORIGIN_Y, $urandom);
        write_reg(bpt_pkg::REG_ORIGIN_Z, $urandom);
        write_reg(bpt_pkg::REG_SCALE_X, $urandom);
        write_reg(bpt_pkg::REG_SCALE_Y, $urandom_range(32'h0400_0000, 32'h0010_0000));
        write_reg(bpt_pkg::REG_SCALE_Z, $urandom_range(32'h0400_0000, 32'h0010_0000));
      end
    endcase
  endtask

  // stimulus
  initial begin
    sb        = new();
    sb.reset_state();
    send_pct  = 23;
    recv_pct  = 52;
    hold_req  = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = bpt_pkg::REG_ORIGIN_X;
    cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: ignored writes and points off the grid
    send_item(coeff_write(11'd1331, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1));
    send_item(coeff_write(11'd2047, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_item(point_query(32'hFFFF_FFFF, 32'h0, 32'h0));
    send_item(point_query(32'h0, 32'h0008_0000, 32'h0));
    send_item(point_query(32'h0, 32'h0, 32'h7FFF_FFFF));
    send_item(point_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_item(point_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));

    // fill the whole control grid
    for (int i = 0; i < STORE_DEPTH; i++)
      send_item(coeff_write(i[10:0], rand_coeff(), rand_coeff(), rand_coeff()));

    // directed: corners, tile edges and extreme coefficients of the grid
    send_item(point_query(32'h0, 32'h0, 32'h0));
    send_item(point_query(32'h0007_FFFF, 32'h0007_FFFF, 32'h0007_FFFF));
    send_item(point_query(32'h0001_8000, 32'h0003_0001, 32'h0005_FFFF));
    send_item(coeff_write(11'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    send_item(coeff_write(11'd1330, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_item(point_query(32'h0, 32'h0, 32'h0));
    send_item(point_query(32'h0007_FFFF, 32'h0007_FFFF, 32'h0007_FFFF));
    send_item(point_query(32'h0000_0001, 32'h0000_8000, 32'h0000_FFFF));

    // random phases under changing settings and idling
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      setup_phase(ph);
      case (ph)
        0: begin send_pct = 23; recv_pct = 52; end
        1: begin send_pct = 52; recv_pct = 23; end
        default: begin send_pct = 0; recv_pct = 0; end
      endcase
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_item());
    end

    in_valid = 1'b0;
    while (sb.due_q.size() != 0) @(negedge clk);
    repeat (450) @(negedge clk);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
